@@ src/lpltx_pkg.sv @@
package lpltx_pkg;

	// transmit phase
	typedef enum logic [1:0] {
		PH_IDLE    = 2'd0,
		PH_SEND    = 2'd1,
		PH_EXPIRED = 2'd2
	} phase_t;

	// input opcodes
	localparam logic [1:0] OP_TX_REQ   = 2'd0;
	localparam logic [1:0] OP_SEND_DONE = 2'd1;
	localparam logic [1:0] OP_TICK     = 2'd2;
	localparam logic [1:0] OP_UNUSED   = 2'd3;

	// result actions
	localparam logic ACT_SEND   = 1'b0;
	localparam logic ACT_REPORT = 1'b1;

	// report codes
	localparam logic [1:0] RC_SUCCESS = 2'd0;
	localparam logic [1:0] RC_FAILED  = 2'd1;
	localparam logic [1:0] RC_BUSY    = 2'd2;

	// configuration register indexes
	localparam logic [1:0] CFG_LISTEN_ENABLED = 2'd0;
	localparam logic [1:0] CFG_LISTEN_WINDOW  = 2'd1;
	localparam logic [1:0] CFG_WAKEUP_INTERVAL = 2'd2;

	localparam logic [7:0] MAX_FRAME_LEN = 8'd127;

	localparam int LEN_W   = 7;
	localparam int TIMER_W = 18;
	localparam int US_W    = 16;

	typedef struct packed {
		logic [1:0]       report_code;
		logic [LEN_W-1:0] send_length;
		logic             action;
	} result_t;

endpackage

@@ src/low_power_listen_tx_control.sv @@
// Channel   Dir  Bits  Contents (lowest bit first)
// s_axis    in   16    opcode[1:0], frame_length[8:2], needs_ack[9], send_ok[10], zero fill
// m_axis    out  16    action[0], send_length[7:1], report_code[9:8], zero fill
// cfg       in   2/16  cfg_we, cfg_index, cfg_data
//
// One word per cycle sustained while m_axis is not stalled; a result passes through the
// input register, then the result register, from which it shows on m_axis. Words that
// produce no result are dropped as they leave the input register.
// arst_n clears all control state and the configuration.
// A stall on m_axis holds the result register; s_axis keeps accepting while the
// input register is empty or moving on.
module low_power_listen_tx_control
	import lpltx_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // opcode, frame_length, needs_ack, send_ok
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // action, send_length, report_code
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	// configuration
	logic              listen_enabled_q;
	logic [US_W-1:0]   listen_window_q;
	logic [US_W-1:0]   wakeup_interval_q;

	// controller state
	phase_t              phase_q, phase_d;
	logic [TIMER_W-1:0]  countdown_q, countdown_d;
	logic                timer_running_q, timer_running_d;
	logic                held_needs_ack_q, held_needs_ack_d;
	logic [LEN_W-1:0]    held_length_q, held_length_d;

	// input stage
	logic             valid_s1;
	logic [1:0]       opcode_s1;
	logic [LEN_W-1:0] frame_length_s1;
	logic             needs_ack_s1;
	logic             send_ok_s1;

	// result stage
	logic    valid_s2;
	result_t result_s2;

	result_t          result_d;
	logic             has_result;
	logic             advance_s1;
	logic [LEN_W-1:0] clamped_len;

	assign advance_s1    = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			listen_enabled_q  <= 1'b0;
			listen_window_q   <= '0;
			wakeup_interval_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_LISTEN_ENABLED:  listen_enabled_q  <= cfg_data[0];
				CFG_LISTEN_WINDOW:   listen_window_q   <= cfg_data;
				CFG_WAKEUP_INTERVAL: wakeup_interval_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			opcode_s1       <= s_axis_tdata[1:0];
			frame_length_s1 <= s_axis_tdata[8:2];
			needs_ack_s1    <= s_axis_tdata[9];
			send_ok_s1      <= s_axis_tdata[10];
		end
	end

	// saturate the requested length
	assign clamped_len = ({1'b0, frame_length_s1} > MAX_FRAME_LEN) ?
		MAX_FRAME_LEN[LEN_W-1:0] : frame_length_s1;

	// next state
	always_comb begin
		phase_d          = phase_q;
		countdown_d      = countdown_q;
		timer_running_d  = timer_running_q;
		held_needs_ack_d = held_needs_ack_q;
		held_length_d    = held_length_q;
		case (opcode_s1)
			OP_TX_REQ: begin
				if (listen_enabled_q && phase_q == PH_IDLE) begin
					phase_d          = PH_SEND;
					held_length_d    = clamped_len;
					held_needs_ack_d = needs_ack_s1;
					countdown_d      = TIMER_W'(wakeup_interval_q)
						+ {1'b0, listen_window_q, 1'b0};
					timer_running_d  = 1'b1;
				end
			end
			OP_SEND_DONE: begin
				if (listen_enabled_q && phase_q != PH_IDLE) begin
					if (held_needs_ack_q && send_ok_s1) begin
						phase_d         = PH_IDLE;
						timer_running_d = 1'b0;
						countdown_d     = '0;
					end else if (phase_q == PH_EXPIRED) begin
						phase_d = PH_IDLE;
					end
				end
			end
			OP_TICK: begin
				if (timer_running_q) begin
					if (countdown_q <= TIMER_W'(1)) begin
						countdown_d     = '0;
						timer_running_d = 1'b0;
						if (phase_q == PH_SEND)
							phase_d = PH_EXPIRED;
					end else begin
						countdown_d = countdown_q - TIMER_W'(1);
					end
				end
			end
			default: ;
		endcase
	end

	// result
	always_comb begin
		has_result = 1'b0;
		result_d   = '0;
		case (opcode_s1)
			OP_TX_REQ: begin
				has_result = 1'b1;
				if (listen_enabled_q && phase_q != PH_IDLE) begin
					result_d.action      = ACT_REPORT;
					result_d.report_code = RC_BUSY;
				end else begin
					result_d.action      = ACT_SEND;
					result_d.send_length = clamped_len;
				end
			end
			OP_SEND_DONE: begin
				if (!listen_enabled_q) begin
					has_result           = 1'b1;
					result_d.action      = ACT_REPORT;
					result_d.report_code = send_ok_s1 ? RC_SUCCESS : RC_FAILED;
				end else if (phase_q != PH_IDLE) begin
					has_result = 1'b1;
					if (held_needs_ack_q && send_ok_s1) begin
						result_d.action      = ACT_REPORT;
						result_d.report_code = RC_SUCCESS;
					end else if (phase_q == PH_EXPIRED) begin
						result_d.action      = ACT_REPORT;
						result_d.report_code = held_needs_ack_q ? RC_FAILED : RC_SUCCESS;
					end else begin
						result_d.action      = ACT_SEND;
						result_d.send_length = held_length_q;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q          <= PH_IDLE;
			countdown_q      <= '0;
			timer_running_q  <= 1'b0;
			held_needs_ack_q <= 1'b0;
			held_length_q    <= '0;
		end else if (advance_s1) begin
			phase_q          <= phase_d;
			countdown_q      <= countdown_d;
			timer_running_q  <= timer_running_d;
			held_needs_ack_q <= held_needs_ack_d;
			held_length_q    <= held_length_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance_s1) begin
			valid_s2 <= has_result;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1 && has_result)
			result_s2 <= result_d;
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {6'd0, result_s2};

endmodule

@@ src/lpltx_checker.sv @@
module lpltx_assertions
	import lpltx_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [15:0] s_axis_tdata,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [15:0] m_axis_tdata
);

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result word changed while stalled");

	a_send_no_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[0] == ACT_SEND |-> m_axis_tdata[9:8] == RC_SUCCESS)
		else $error("send word carries a report code");

	a_report_no_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[0] == ACT_REPORT |->
			m_axis_tdata[7:1] == '0 && m_axis_tdata[9:8] <= RC_BUSY)
		else $error("malformed report word");

	a_len_limit: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> {1'b0, m_axis_tdata[7:1]} <= MAX_FRAME_LEN)
		else $error("send length above limit");

	// a tick word never produces a result: once the word ahead of it has left with
	// nothing shown, the output stays idle as the tick moves through
	a_tick_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready && s_axis_tdata[1:0] == OP_TICK)
			##1 (!m_axis_tvalid) |=> !m_axis_tvalid)
		else $error("result appeared out of nowhere");

endmodule

bind low_power_listen_tx_control lpltx_assertions u_lpltx_assertions (.*);
